// ----- src/owt_pkg.sv -----
// owt_pkg: shared types and constants for the 1-wire temperature read sequencer
// used by owt_core and by the top level onewire_temperature_read_sequencer
package owt_pkg;

    localparam int TIMER_W = 20;
    localparam int TEMP_W  = 16;

    // rom / function commands
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;

    // reset pulse timing, in ticks
    localparam int RST_SAMPLE_TICKS = 2;
    localparam int RST_MAX_TRIES    = 124;
    localparam int RST_LOW_TICKS    = 492;
    localparam int RST_REL_TICKS    = 40;
    localparam int RST_REC_TICKS    = 420;

    // write and read slot timing, in ticks
    localparam int WR_ONE_LOW    = 5;
    localparam int WR_ZERO_LOW   = 55;
    localparam int WR_SLOT_TICKS = 60;
    localparam int RD_LOW_TICKS  = 3;
    localparam int RD_SAMPLE_AT  = 12;
    localparam int RD_SLOT_TICKS = 66;

    // result of one tick
    typedef struct packed {
        logic               drive_low;
        logic               busy;
        logic               done;
        logic               present;
        logic signed [15:0] temperature;
    } owt_res_t;

endpackage

// ----- src/owt_core.sv -----
// owt_core: sequencer state and the one-tick step logic of the 1-wire master
// depends on owt_pkg for timing constants, commands and the result struct
module owt_core #(
    parameter int SCRATCH_BYTES = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          start_req,
    input  logic                          line_level,
    input  logic [owt_pkg::TIMER_W-1:0]   conversion_wait,
    output owt_pkg::owt_res_t             res
);
    import owt_pkg::*;

    localparam int BC_W = $clog2(SCRATCH_BYTES + 1);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_WAKE_RST   = 4'd1;
    localparam logic [3:0] PH_CONV_RST   = 4'd2;
    localparam logic [3:0] PH_WR_SKIP1   = 4'd3;
    localparam logic [3:0] PH_WR_CONVERT = 4'd4;
    localparam logic [3:0] PH_CONV_WAIT  = 4'd5;
    localparam logic [3:0] PH_READ_RST   = 4'd6;
    localparam logic [3:0] PH_WR_SKIP2   = 4'd7;
    localparam logic [3:0] PH_WR_READSP  = 4'd8;
    localparam logic [3:0] PH_RD_BYTES   = 4'd9;

    localparam logic [1:0] RS_WAIT = 2'd0;
    localparam logic [1:0] RS_LOW  = 2'd1;
    localparam logic [1:0] RS_REL  = 2'd2;
    localparam logic [1:0] RS_REC  = 2'd3;

    logic [3:0]         phase_reg,       phase_next;
    logic [TIMER_W-1:0] tick_timer_reg,  tick_timer_next;
    logic [2:0]         bit_pos_reg,     bit_pos_next;
    logic [BC_W-1:0]    byte_count_reg,  byte_count_next;
    logic [7:0]         shift_byte_reg,  shift_byte_next;
    logic [6:0]         tries_reg,       tries_next;
    logic               woken_reg,       woken_next;
    logic               present_reg,     present_next;
    logic [7:0]         low_byte_reg,    low_byte_next;
    logic [TEMP_W-1:0]  reading_reg,     reading_next;
    logic [1:0]         rst_sub_reg,     rst_sub_next;
    logic               rst_seen_reg,    rst_seen_next;
    logic               drive;
    logic               done;

    always_comb
    begin
        logic [TIMER_W-1:0] t1;
        logic [6:0]         tries_inc;
        logic [7:0]         cmd;
        logic               one_bit;
        logic               rst_fin;
        logic               wr_fin;
        logic [7:0]         shift_cur;
        logic [BC_W-1:0]    bc_inc;

        phase_next      = phase_reg;
        tick_timer_next = tick_timer_reg;
        bit_pos_next    = bit_pos_reg;
        byte_count_next = byte_count_reg;
        shift_byte_next = shift_byte_reg;
        tries_next      = tries_reg;
        woken_next      = woken_reg;
        present_next    = present_reg;
        low_byte_next   = low_byte_reg;
        reading_next    = reading_reg;
        rst_sub_next    = rst_sub_reg;
        rst_seen_next   = rst_seen_reg;
        drive           = 1'b0;
        done            = 1'b0;

        t1        = tick_timer_reg + 1'b1;
        tries_inc = tries_reg + 1'b1;
        rst_fin   = 1'b0;
        wr_fin    = 1'b0;
        shift_cur = shift_byte_reg;
        bc_inc    = byte_count_reg + 1'b1;

        // reset pulse sub-sequence
        tick_timer_next = t1;
        case (rst_sub_reg)
            RS_WAIT:
            begin
                if (t1 >= TIMER_W'(RST_SAMPLE_TICKS))
                begin
                    tick_timer_next = '0;
                    if (line_level)
                    begin
                        tries_next   = '0;
                        rst_sub_next = RS_LOW;
                    end
                    else if (tries_inc >= 7'(RST_MAX_TRIES))
                    begin
                        tries_next    = '0;
                        rst_seen_next = 1'b0;
                        rst_fin       = 1'b1;
                    end
                    else
                    begin
                        tries_next = tries_inc;
                    end
                end
            end
            RS_LOW:
            begin
                if (t1 >= TIMER_W'(RST_LOW_TICKS))
                begin
                    tick_timer_next = '0;
                    rst_sub_next    = RS_REL;
                end
            end
            RS_REL:
            begin
                if (t1 >= TIMER_W'(RST_REL_TICKS))
                begin
                    tick_timer_next = '0;
                    rst_seen_next   = ~line_level;
                    rst_sub_next    = RS_REC;
                end
            end
            default:
            begin
                if (t1 >= TIMER_W'(RST_REC_TICKS))
                begin
                    tick_timer_next = '0;
                    rst_fin         = 1'b1;
                end
            end
        endcase

        // reset values above apply only in reset phases
        if (!(phase_reg == PH_WAKE_RST || phase_reg == PH_CONV_RST ||
              phase_reg == PH_READ_RST))
        begin
            tick_timer_next = tick_timer_reg;
            tries_next      = tries_reg;
            rst_sub_next    = rst_sub_reg;
            rst_seen_next   = rst_seen_reg;
            rst_fin         = 1'b0;
        end

        case (phase_reg)
            PH_WR_CONVERT: cmd = CMD_CONVERT;
            PH_WR_READSP:  cmd = CMD_READ_SP;
            default:       cmd = CMD_SKIP_ROM;
        endcase
        one_bit = cmd[bit_pos_reg];

        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    phase_next      = woken_reg ? PH_CONV_RST : PH_WAKE_RST;
                    rst_sub_next    = RS_WAIT;
                    rst_seen_next   = 1'b0;
                    tick_timer_next = '0;
                    tries_next      = '0;
                end
            end
            PH_WAKE_RST, PH_CONV_RST, PH_READ_RST:
            begin
                drive = (rst_sub_reg == RS_LOW);
                if (rst_fin)
                begin
                    if (phase_reg == PH_WAKE_RST)
                    begin
                        woken_next      = 1'b1;
                        phase_next      = PH_CONV_RST;
                        rst_sub_next    = RS_WAIT;
                        rst_seen_next   = 1'b0;
                        tick_timer_next = '0;
                        tries_next      = '0;
                    end
                    else
                    begin
                        if (phase_reg == PH_CONV_RST)
                        begin
                            present_next = rst_seen_next;
                            phase_next   = PH_WR_SKIP1;
                        end
                        else
                        begin
                            phase_next = PH_WR_SKIP2;
                        end
                        tick_timer_next = '0;
                        bit_pos_next    = '0;
                    end
                end
            end
            PH_WR_SKIP1, PH_WR_CONVERT, PH_WR_SKIP2, PH_WR_READSP:
            begin
                drive = one_bit ? (tick_timer_reg < TIMER_W'(WR_ONE_LOW))
                                : (tick_timer_reg < TIMER_W'(WR_ZERO_LOW));
                tick_timer_next = t1;
                if (t1 >= TIMER_W'(WR_SLOT_TICKS))
                begin
                    tick_timer_next = '0;
                    if (bit_pos_reg == 3'd7)
                    begin
                        bit_pos_next = '0;
                        wr_fin       = 1'b1;
                    end
                    else
                    begin
                        bit_pos_next = bit_pos_reg + 1'b1;
                    end
                end
                if (wr_fin)
                begin
                    case (phase_reg)
                        PH_WR_SKIP1:
                        begin
                            phase_next = PH_WR_CONVERT;
                        end
                        PH_WR_SKIP2:
                        begin
                            phase_next = PH_WR_READSP;
                        end
                        PH_WR_READSP:
                        begin
                            phase_next      = PH_RD_BYTES;
                            byte_count_next = '0;
                            shift_byte_next = '0;
                        end
                        default:
                        begin
                            // end of convert command
                            if (!present_reg)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else if (conversion_wait == '0)
                            begin
                                phase_next    = PH_READ_RST;
                                rst_sub_next  = RS_WAIT;
                                rst_seen_next = 1'b0;
                                tries_next    = '0;
                            end
                            else
                            begin
                                phase_next = PH_CONV_WAIT;
                            end
                        end
                    endcase
                end
            end
            PH_CONV_WAIT:
            begin
                tick_timer_next = t1;
                if (t1 >= conversion_wait)
                begin
                    phase_next      = PH_READ_RST;
                    rst_sub_next    = RS_WAIT;
                    rst_seen_next   = 1'b0;
                    tick_timer_next = '0;
                    tries_next      = '0;
                end
            end
            PH_RD_BYTES:
            begin
                drive = (tick_timer_reg < TIMER_W'(RD_LOW_TICKS));
                if (tick_timer_reg == TIMER_W'(RD_SAMPLE_AT) && line_level)
                begin
                    shift_cur[bit_pos_reg] = 1'b1;
                end
                shift_byte_next = shift_cur;
                tick_timer_next = t1;
                if (t1 >= TIMER_W'(RD_SLOT_TICKS))
                begin
                    tick_timer_next = '0;
                    if (bit_pos_reg != 3'd7)
                    begin
                        bit_pos_next = bit_pos_reg + 1'b1;
                    end
                    else
                    begin
                        bit_pos_next = '0;
                        if (byte_count_reg == '0)
                        begin
                            low_byte_next = shift_cur;
                        end
                        else if (byte_count_reg == BC_W'(1))
                        begin
                            reading_next = {shift_cur, low_byte_reg};
                        end
                        shift_byte_next = '0;
                        byte_count_next = bc_inc;
                        if (bc_inc >= BC_W'(SCRATCH_BYTES))
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next      = PH_IDLE;
                tick_timer_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_timer_reg <= '0;
            bit_pos_reg    <= '0;
            byte_count_reg <= '0;
            shift_byte_reg <= '0;
            tries_reg      <= '0;
            woken_reg      <= 1'b0;
            present_reg    <= 1'b0;
            low_byte_reg   <= '0;
            reading_reg    <= '0;
            rst_sub_reg    <= RS_WAIT;
            rst_seen_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            tick_timer_reg <= tick_timer_next;
            bit_pos_reg    <= bit_pos_next;
            byte_count_reg <= byte_count_next;
            shift_byte_reg <= shift_byte_next;
            tries_reg      <= tries_next;
            woken_reg      <= woken_next;
            present_reg    <= present_next;
            low_byte_reg   <= low_byte_next;
            reading_reg    <= reading_next;
            rst_sub_reg    <= rst_sub_next;
            rst_seen_reg   <= rst_seen_next;
        end
    end

    assign res.drive_low   = drive;
    assign res.busy        = (phase_next != PH_IDLE);
    assign res.done        = done;
    assign res.present     = present_next;
    assign res.temperature = signed'(reading_next);

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && phase_reg == PH_IDLE && !start_req |=> phase_reg == PH_IDLE)
        else $error("idle left without a start");

    a_no_drive_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE || phase_reg == PH_CONV_WAIT |-> !res.drive_low)
        else $error("bus driven while idle or waiting for conversion");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.done |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(tick_timer_reg))
        else $error("sequencer state moved without a tick");

endmodule

// ----- src/onewire_temperature_read_sequencer.sv -----
// onewire_temperature_read_sequencer: top level of the 1-wire temperature reader
// holds the input, output and conversion_wait registers; uses owt_pkg and owt_core
//
// channel   signals                                   direction
// in        in_valid, in_stall, start_req, line_level  tick request in
// out       out_valid, out_stall, drive_low, busy_res,  result out
//           done_res, sensor_present, temperature
// cfg       cfg_wr_en, cfg_wr_data                      conversion_wait write
//
// one request per clock while in_stall is low; its result is registered once the output is open
// the step logic sits between the input register and the result register
// reset clears the sequencer to idle, conversion_wait to 800000, no wake-up done
// out_stall holds the result register and backs up to in_stall in the same cycle
module onewire_temperature_read_sequencer #(
    parameter int SCRATCH_BYTES = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        start_req,
    input  logic                        line_level,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        drive_low,
    output logic                        busy_res,
    output logic                        done_res,
    output logic                        sensor_present,
    output logic signed [15:0]          temperature,
    input  logic                        cfg_wr_en,
    input  logic [owt_pkg::TIMER_W-1:0] cfg_wr_data
);
    import owt_pkg::*;

    localparam logic [TIMER_W-1:0] CONV_WAIT_RESET = TIMER_W'(800000);

    logic               in_valid_reg;
    logic               start_reg;
    logic               line_reg;
    logic               out_valid_reg;
    owt_res_t           out_reg;
    logic [TIMER_W-1:0] conv_wait_reg;
    owt_res_t           step_res;
    logic               out_open;
    logic               step_en;

    assign out_open = !out_valid_reg || !out_stall;
    assign step_en  = in_valid_reg && out_open;
    assign in_stall = in_valid_reg && !out_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            conv_wait_reg <= CONV_WAIT_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_open)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en)
            begin
                conv_wait_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            start_reg <= start_req;
            line_reg  <= line_level;
        end
        if (step_en)
        begin
            out_reg <= step_res;
        end
    end

    owt_core #(
        .SCRATCH_BYTES (SCRATCH_BYTES)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (step_en),
        .start_req       (start_reg),
        .line_level      (line_reg),
        .conversion_wait (conv_wait_reg),
        .res             (step_res)
    );

    assign out_valid      = out_valid_reg;
    assign drive_low      = out_reg.drive_low;
    assign busy_res       = out_reg.busy;
    assign done_res       = out_reg.done;
    assign sensor_present = out_reg.present;
    assign temperature    = out_reg.temperature;

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for onewire_temperature_read_sequencer
// drives bus ticks as whole measurement runs and predicts each result in a scoreboard class
// depends on owt_pkg and the top level onewire_temperature_read_sequencer
module tb_top;
    import owt_pkg::*;

    localparam int SCRATCH_N      = 9;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;

    // bus timing and commands, in ticks
    localparam int SAMPLE_GAP   = 2;
    localparam int MAX_TRIES    = 124;
    localparam int LOW_TICKS    = 492;
    localparam int REL_TICKS    = 40;
    localparam int REC_TICKS    = 420;
    localparam int ONE_LOW      = 5;
    localparam int ZERO_LOW     = 55;
    localparam int WR_SLOT      = 60;
    localparam int RD_LOW       = 3;
    localparam int RD_SAMPLE    = 12;
    localparam int RD_SLOT      = 66;
    localparam logic [7:0] SKIP_ROM = 8'hCC;
    localparam logic [7:0] CONVERT  = 8'h44;
    localparam logic [7:0] READ_SP  = 8'hBE;
    localparam logic [19:0] WAIT_MAX = 20'hFFFFF;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE_RST, PH_CONV_RST, PH_WR_SKIP1, PH_WR_CONVERT,
        PH_CONV_WAIT, PH_READ_RST, PH_WR_SKIP2, PH_WR_READSP, PH_RD_BYTES
    } seq_phase_t;

    typedef enum logic [1:0] {RS_WAIT, RS_LOW, RS_REL, RS_REC} rst_step_t;

    typedef enum int {BUS_SENSOR, BUS_ABSENT, BUS_STUCK, BUS_LATE_STUCK, BUS_NOISE} bus_mode_t;

    class sensor_read_tracker;
        logic [19:0] conv_wait;
        seq_phase_t  ph;
        rst_step_t   rsub;
        logic [19:0] timer;
        logic [2:0]  bitpos;
        logic [3:0]  nbytes;
        logic [7:0]  shreg;
        logic [6:0]  tries;
        bit          woken;
        bit          present;
        bit          seen;
        logic [7:0]  lo_byte;
        logic [15:0] reading;
        owt_res_t    expected_ticks[$];
        int          n_requests;
        int          n_errors;
        int          n_readings;
        int          n_no_sensor;
        int          n_failed_resets;

        function new();
            conv_wait = 20'd800000;
            ph        = PH_IDLE;
            rsub      = RS_WAIT;
            timer     = '0;
            bitpos    = '0;
            nbytes    = '0;
            shreg     = '0;
            tries     = '0;
            woken     = 0;
            present   = 0;
            seen      = 0;
            lo_byte   = '0;
            reading   = '0;
        endfunction

        function void open_reset(seq_phase_t p);
            ph    = p;
            rsub  = RS_WAIT;
            seen  = 0;
            timer = '0;
            tries = '0;
        endfunction

        function void open_xfer(seq_phase_t p);
            ph     = p;
            timer  = '0;
            bitpos = '0;
        endfunction

        function bit reset_step(bit line);
            timer = timer + 1'b1;
            case (rsub)
                RS_WAIT:
                    if (timer >= SAMPLE_GAP)
                    begin
                        timer = '0;
                        if (line)
                        begin
                            tries = '0;
                            rsub  = RS_LOW;
                        end
                        else
                        begin
                            tries = tries + 1'b1;
                            if (tries >= MAX_TRIES)
                            begin
                                tries = '0;
                                seen  = 0;
                                n_failed_resets++;
                                return 1;
                            end
                        end
                    end
                RS_LOW:
                    if (timer >= LOW_TICKS)
                    begin
                        timer = '0;
                        rsub  = RS_REL;
                    end
                RS_REL:
                    if (timer >= REL_TICKS)
                    begin
                        timer = '0;
                        seen  = !line;
                        rsub  = RS_REC;
                    end
                default:
                    if (timer >= REC_TICKS)
                    begin
                        timer = '0;
                        return 1;
                    end
            endcase
            return 0;
        endfunction

        function bit write_step(logic [7:0] value, output bit drv);
            drv   = timer < (value[bitpos] ? ONE_LOW : ZERO_LOW);
            timer = timer + 1'b1;
            if (timer >= WR_SLOT)
            begin
                timer = '0;
                if (bitpos == 3'd7)
                begin
                    bitpos = '0;
                    return 1;
                end
                bitpos = bitpos + 1'b1;
            end
            return 0;
        endfunction

        function bit read_step(bit line, output bit drv);
            drv = timer < RD_LOW;
            if (timer == RD_SAMPLE && line)
                shreg[bitpos] = 1'b1;
            timer = timer + 1'b1;
            if (timer >= RD_SLOT)
            begin
                timer = '0;
                if (bitpos < 3'd7)
                begin
                    bitpos = bitpos + 1'b1;
                    return 0;
                end
                bitpos = '0;
                if (nbytes == 0)
                    lo_byte = shreg;
                else if (nbytes == 1)
                    reading = {shreg, lo_byte};
                shreg  = '0;
                nbytes = nbytes + 1'b1;
                if (nbytes >= SCRATCH_N)
                    return 1;
            end
            return 0;
        endfunction

        // advance one tick and queue the result it must produce
        function void note_request(bit start, bit line);
            owt_res_t r;
            bit       drv;
            bit       fin;
            drv = 0;
            fin = 0;
            n_requests++;
            case (ph)
                PH_IDLE:
                    if (start)
                        open_reset(woken ? PH_CONV_RST : PH_WAKE_RST);
                PH_WAKE_RST, PH_CONV_RST, PH_READ_RST:
                begin
                    drv = (rsub == RS_LOW);
                    if (reset_step(line))
                    begin
                        if (ph == PH_WAKE_RST)
                        begin
                            woken = 1;
                            open_reset(PH_CONV_RST);
                        end
                        else if (ph == PH_CONV_RST)
                        begin
                            present = seen;
                            open_xfer(PH_WR_SKIP1);
                        end
                        else
                            open_xfer(PH_WR_SKIP2);
                    end
                end
                PH_WR_SKIP1:
                    if (write_step(SKIP_ROM, drv))
                        open_xfer(PH_WR_CONVERT);
                PH_WR_CONVERT:
                    if (write_step(CONVERT, drv))
                    begin
                        if (!present)
                        begin
                            ph  = PH_IDLE;
                            fin = 1;
                            n_no_sensor++;
                        end
                        else if (conv_wait == 0)
                            open_reset(PH_READ_RST);
                        else
                        begin
                            ph    = PH_CONV_WAIT;
                            timer = '0;
                        end
                    end
                PH_CONV_WAIT:
                begin
                    timer = timer + 1'b1;
                    if (timer >= conv_wait)
                        open_reset(PH_READ_RST);
                end
                PH_WR_SKIP2:
                    if (write_step(SKIP_ROM, drv))
                        open_xfer(PH_WR_READSP);
                PH_WR_READSP:
                    if (write_step(READ_SP, drv))
                    begin
                        open_xfer(PH_RD_BYTES);
                        nbytes = '0;
                        shreg  = '0;
                    end
                PH_RD_BYTES:
                    if (read_step(line, drv))
                    begin
                        ph  = PH_IDLE;
                        fin = 1;
                        n_readings++;
                    end
                default:
                begin
                    ph    = PH_IDLE;
                    timer = '0;
                end
            endcase
            r.drive_low   = drv;
            r.busy        = (ph != PH_IDLE);
            r.done        = fin;
            r.present     = present;
            r.temperature = reading;
            expected_ticks.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [16:0] want,
                                    logic signed [16:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(owt_res_t got);
            owt_res_t want;
            if (expected_ticks.size() == 0)
            begin
                $error("result with no request pending: drive_low %0d busy_res %0d temperature %0d",
                       got.drive_low, got.busy, got.temperature);
                n_errors++;
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("drive_low", want.drive_low, got.drive_low);
            compare_field("busy_res", want.busy, got.busy);
            compare_field("done_res", want.done, got.done);
            compare_field("sensor_present", want.present, got.present);
            compare_field("temperature", want.temperature, got.temperature);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                start_req;
    logic                line_level;
    logic                out_valid;
    logic                out_stall;
    logic                drive_low;
    logic                busy_res;
    logic                done_res;
    logic                sensor_present;
    logic signed [15:0]  temperature;
    logic                cfg_wr_en;
    logic [TIMER_W-1:0]  cfg_wr_data;

    sensor_read_tracker board;
    int                 sender_pct;
    int                 recv_pct;
    int                 calm_left;
    int                 quiet_cycles;
    bit                 use_pattern;
    logic [23:0]        read_pattern;

    onewire_temperature_read_sequencer #(
        .SCRATCH_BYTES (SCRATCH_N)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_req      (start_req),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .sensor_present (sensor_present),
        .temperature    (temperature),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit want_idle(int pct);
        return calm_left == 0 && $urandom_range(0, 99) < pct;
    endfunction

    // bus level a sensor in the given mode would show on the next tick
    function automatic bit pick_line(bus_mode_t mode);
        bit in_rst;
        in_rst = (board.ph == PH_WAKE_RST || board.ph == PH_CONV_RST ||
                  board.ph == PH_READ_RST);
        if (in_rst && board.rsub == RS_WAIT)
        begin
            if (mode == BUS_STUCK || (mode == BUS_LATE_STUCK && board.ph == PH_READ_RST))
                return 1'b0;
            if (mode == BUS_NOISE)
                return 1'($urandom_range(0, 1));
            return $urandom_range(0, 3) != 0;
        end
        // last released tick of the reset decides presence
        if (in_rst && board.rsub == RS_REL && board.timer == REL_TICKS - 1)
        begin
            if (mode == BUS_ABSENT)
                return 1'b1;
            if ((mode == BUS_SENSOR || mode == BUS_LATE_STUCK) && board.ph != PH_READ_RST)
                return 1'b0;
            return 1'($urandom_range(0, 1));
        end
        // the pattern covers the first three scratchpad bytes only
        if (board.ph == PH_RD_BYTES && use_pattern && board.nbytes < 4'd3)
            return read_pattern[board.nbytes * 8 + board.bitpos];
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_tick(bit s, bit l);
        while (want_idle(sender_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_req  <= s;
        line_level <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(s, l);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_conv_wait(logic [19:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.conv_wait = value;
    endtask

    // one measurement: a few idle ticks, the start request, then ticks until idle
    task automatic run_sequence(bus_mode_t mode);
        int lead;
        lead = $urandom_range(0, 3);
        repeat (lead) send_tick(1'b0, 1'($urandom_range(0, 1)));
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        while (board.ph != PH_IDLE)
            send_tick($urandom_range(0, 7) == 0, pick_line(mode));
    endtask

    task automatic run_reading(logic [15:0] value);
        use_pattern  = 1;
        read_pattern = {8'($urandom_range(0, 255)), value};
        run_sequence(BUS_SENSOR);
        use_pattern = 0;
    endtask

    function automatic bus_mode_t random_mode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return BUS_SENSOR;
        if (pick < 72)
            return BUS_ABSENT;
        if (pick < 80)
            return BUS_STUCK;
        if (pick < 88)
            return BUS_LATE_STUCK;
        return BUS_NOISE;
    endfunction

    function automatic logic [19:0] random_wait();
        if ($urandom_range(0, 3) == 0)
            return 20'($urandom_range(0, 2000));
        return 20'($urandom_range(0, 40));
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_result({drive_low, busy_res, done_res, sensor_present, temperature});
        out_stall <= rst_n && want_idle(recv_pct);
        // occasional stretches where neither side holds back
        if (calm_left > 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(0, 299) == 0)
            calm_left <= $urandom_range(20, 80);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int nseq;
        board        = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        start_req    = 1'b0;
        line_level   = 1'b0;
        out_stall    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        sender_pct   = 0;
        recv_pct     = 0;
        calm_left    = 0;
        quiet_cycles = 0;
        use_pattern  = 0;
        read_pattern = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default wait, bus held low: wake-up and convert resets both time out
        run_sequence(BUS_STUCK);
        write_conv_wait('0);
        run_reading(16'h8000);
        write_conv_wait(20'd1);
        run_reading(16'h7FFF);
        run_reading(16'hFFFF);
        run_sequence(BUS_LATE_STUCK);
        write_conv_wait(WAIT_MAX);
        run_sequence(BUS_ABSENT);
        write_conv_wait(20'd17);
        run_reading(16'h0000);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin sender_pct = 0;  recv_pct = 0;  nseq = 8; end
                1: begin sender_pct = 87; recv_pct = 0;  nseq = 4; end
                2: begin sender_pct = 0;  recv_pct = 87; nseq = 4; end
                default: begin sender_pct = 35; recv_pct = 35; nseq = 6; end
            endcase
            for (int k = 0; k < nseq; k++)
            begin
                if ($urandom_range(0, 1))
                    write_conv_wait(random_wait());
                run_sequence(random_mode());
            end
        end
        drain_results();

        $display("ran %0d bus ticks: %0d readings, %0d runs without a sensor, %0d reset timeouts",
                 board.n_requests, board.n_readings, board.n_no_sensor, board.n_failed_resets);
        $display("conversion wait from 0 to its maximum, sender and receiver idling mixed");
        if (board.n_errors == 0 && board.expected_ticks.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
